FILE: rtl/core/tib_pkg.sv
`timescale 1ns / 1ps

package tib_pkg;

    // Geometry and icon table
    localparam int COORD_BITS = 12;
    localparam int MAX_ICONS  = 8;
    localparam int VALID_POS  = 4 * COORD_BITS;
    localparam int RECT_W     = VALID_POS + 1;
    localparam int ICON_W     = 4;
    localparam int HIC_W      = 3;
    localparam int TIME_W     = 32;

    // APB register file
    localparam int APB_DW     = 64;
    localparam int APB_AW     = 6;
    localparam int REG_LSB    = 3;

    localparam logic [ICON_W-1:0] NO_ICON = '1;

    // Timing limits in ms
    localparam logic [TIME_W-1:0] HOLD_MS   = TIME_W'(2000);
    localparam logic [TIME_W-1:0] REPEAT_MS = TIME_W'(50);

    typedef enum logic [1:0] {
        HL_NONE    = 2'd0,
        HL_PRESS   = 2'd1,
        HL_RELEASE = 2'd2
    } t_highlight;

    typedef logic [MAX_ICONS-1:0][RECT_W-1:0] t_rect_tbl;

    typedef struct packed {
        logic [COORD_BITS-1:0] touch_x;
        logic [COORD_BITS-1:0] touch_y;
        logic                  is_pressed;
        logic                  is_touchscreen;
        logic [TIME_W-1:0]     event_time;
    } t_touch_word;

    typedef struct packed {
        logic signed [ICON_W-1:0] icon_result;
        logic                     repeat_res;
        logic [1:0]               highlight_action;
        logic [HIC_W-1:0]         highlight_icon;
    } t_result_word;

    typedef struct packed {
        logic              hit;
        logic [ICON_W-1:0] idx;
    } t_hit;

endpackage

FILE: rtl/core/tib_in_if.sv
`timescale 1ns / 1ps

interface tib_in_if;
    logic                 valid;
    logic                 ready;
    tib_pkg::t_touch_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/tib_out_if.sv
`timescale 1ns / 1ps

interface tib_out_if;
    logic                  valid;
    logic                  ready;
    tib_pkg::t_result_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/touch_icon_button_autorepeat.sv
`timescale 1ns / 1ps

// Touch icon button with long-press auto-repeat. Each touch word gives exactly one
// result word, through the input register, then hit test and state update into the
// result register. A new word is taken every cycle unless output ready stalls the
// stages; the rate is set by the combinational priority hit test over the eight icon
// rectangles feeding the held/repeat state update. Input ready follows output ready
// combinationally through the two stages. Icon rectangles are 64-bit APB registers
// at byte address 8*i, icon 0 first; the list ends at the first rectangle whose valid
// bit is clear. A hold of more than 2000 ms on one icon enters repeat mode, then a
// repeat result comes on each pressed word more than 50 ms after the last one.
module touch_icon_button_autorepeat (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tib_in_if.sink                     i_touch,
    tib_out_if.source                  o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tib_pkg::APB_AW-1:0] paddr,
    input  logic [tib_pkg::APB_DW-1:0] pwdata,
    output logic [tib_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import tib_pkg::*;

    t_rect_tbl rects;

    tib_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rects (rects)
    );

    tib_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rects  (rects),
        .i_touch  (i_touch),
        .o_result (o_result)
    );

endmodule

FILE: rtl/core/tib_regs.sv
`timescale 1ns / 1ps

module tib_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tib_pkg::APB_AW-1:0] paddr,
    input  logic [tib_pkg::APB_DW-1:0] pwdata,
    output logic [tib_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output tib_pkg::t_rect_tbl         o_rects
);
    import tib_pkg::*;

    t_rect_tbl                    r_rects;
    logic [APB_AW-REG_LSB-1:0]    reg_sel;
    logic                         wr_en;

    assign reg_sel = paddr[APB_AW-1:REG_LSB];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // rectangle registers, one per icon
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rects <= '0;
        end else if (wr_en) begin
            r_rects[reg_sel] <= pwdata[RECT_W-1:0];
        end
    end

    // read back, zero extended
    assign prdata  = APB_DW'(r_rects[reg_sel]);
    assign o_rects = r_rects;

endmodule

FILE: rtl/core/tib_hit.sv
`timescale 1ns / 1ps

module tib_hit (
    input  tib_pkg::t_rect_tbl             i_rects,
    input  logic [tib_pkg::COORD_BITS-1:0] i_x,
    input  logic [tib_pkg::COORD_BITS-1:0] i_y,
    output tib_pkg::t_hit                  o_hit
);
    import tib_pkg::*;

    logic [MAX_ICONS-1:0] inside_rect;
    logic [MAX_ICONS-1:0] live;

    // per-icon containment; the list is live up to the first invalid entry
    always_comb begin
        logic [COORD_BITS-1:0] lft, top, rgt, bot;
        logic                  open_list;
        open_list = 1'b1;
        for (int i = 0; i < MAX_ICONS; i++) begin
            lft = i_rects[i][COORD_BITS-1:0];
            top = i_rects[i][2*COORD_BITS-1:COORD_BITS];
            rgt = i_rects[i][3*COORD_BITS-1:2*COORD_BITS];
            bot = i_rects[i][4*COORD_BITS-1:3*COORD_BITS];
            inside_rect[i] = (i_x >= lft) && (i_x <= rgt) && (i_y >= top) && (i_y <= bot);
            open_list = open_list && i_rects[i][VALID_POS];
            live[i]   = open_list;
        end
    end

    // first hit wins
    always_comb begin
        o_hit.hit = 1'b0;
        o_hit.idx = NO_ICON;
        for (int i = MAX_ICONS - 1; i >= 0; i--) begin
            if (live[i] && inside_rect[i]) begin
                o_hit.hit = 1'b1;
                o_hit.idx = ICON_W'(i);
            end
        end
    end

endmodule

FILE: rtl/core/tib_ctrl.sv
`timescale 1ns / 1ps

module tib_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tib_pkg::t_rect_tbl i_rects,
    tib_in_if.sink             i_touch,
    tib_out_if.source          o_result
);
    import tib_pkg::*;

    // input stage
    logic        r_in_vld;
    t_touch_word r_in;

    // button state
    logic              r_held;
    logic              r_repeating;
    logic [ICON_W-1:0] r_held_icon;
    logic [TIME_W-1:0] r_last_time;
    logic              n_held;
    logic              n_repeating;
    logic [ICON_W-1:0] n_held_icon;
    logic [TIME_W-1:0] n_last_time;

    // result stage
    logic         r_out_vld;
    t_result_word r_out;
    t_result_word n_out;

    t_hit              hit;
    logic [ICON_W-1:0] idx;
    logic [TIME_W-1:0] dt;
    logic              over_hold;
    logic              over_rep;
    logic              fire;
    logic              in_take;

    tib_hit u_hit (
        .i_rects (i_rects),
        .i_x     (r_in.touch_x),
        .i_y     (r_in.touch_y),
        .o_hit   (hit)
    );

    // handshake: each stage moves when the one after it has room
    assign fire          = r_in_vld && (!r_out_vld || o_result.ready);
    assign i_touch.ready = !r_in_vld || fire;
    assign in_take       = i_touch.valid && i_touch.ready;

    assign idx       = r_in.is_touchscreen ? hit.idx : NO_ICON;
    assign dt        = r_in.event_time - r_last_time;
    assign over_hold = (dt > HOLD_MS) && !dt[TIME_W-1];
    assign over_rep  = (dt > REPEAT_MS) && !dt[TIME_W-1];

    // press / release / repeat decision
    always_comb begin
        logic [ICON_W-1:0] res;
        logic              rep;
        t_highlight        act;
        logic [HIC_W-1:0]  hic;
        n_held      = r_held;
        n_repeating = r_repeating;
        n_held_icon = r_held_icon;
        n_last_time = r_last_time;
        res         = NO_ICON;
        rep         = 1'b0;
        act         = HL_NONE;
        hic         = '0;
        if (!r_in.is_pressed) begin
            if (r_held) begin
                act         = HL_RELEASE;
                hic         = r_held_icon[HIC_W-1:0];
                n_held      = 1'b0;
                n_repeating = 1'b0;
                if (r_held_icon == idx) begin
                    res = idx;
                end else begin
                    n_held_icon = NO_ICON;
                end
            end
        end else if (idx != NO_ICON) begin
            if (!r_held) begin
                n_held      = 1'b1;
                n_held_icon = idx;
                n_last_time = r_in.event_time;
                act         = HL_PRESS;
                hic         = idx[HIC_W-1:0];
            end else if (r_held_icon == idx) begin
                if (!r_repeating && over_hold) begin
                    // entering repeat restarts the timer, no repeat yet
                    n_repeating = 1'b1;
                    n_last_time = r_in.event_time;
                end else if (r_repeating && over_rep) begin
                    rep         = 1'b1;
                    n_last_time = r_in.event_time;
                    res         = r_held_icon;
                end
            end
        end
        n_out.icon_result      = $signed(res);
        n_out.repeat_res       = rep;
        n_out.highlight_action = act;
        n_out.highlight_icon   = hic;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_held      <= 1'b0;
            r_repeating <= 1'b0;
            r_held_icon <= NO_ICON;
            r_last_time <= '0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld   <= 1'b1;
                r_held      <= n_held;
                r_repeating <= n_repeating;
                r_held_icon <= n_held_icon;
                r_last_time <= n_last_time;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_touch.payload;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid   = r_out_vld;
    assign o_result.payload = r_out;

endmodule
